// File: design/e2q_pkg.sv
//------------------------------------------------------------------------------
// e2q_pkg
// shared types, constants and fixed-point helpers for the euler-to-quaternion core
//------------------------------------------------------------------------------
package e2q_pkg;

    localparam int unsigned PHASE_BITS = 32;
    localparam int unsigned Q          = 30;
    localparam logic [31:0] PI4_Q32    = 32'd3373259426;
    localparam int unsigned NUM_TERMS  = 6;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    // horner divisors, applied in order
    localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // each divisor is 2^pre times an odd part; the odd part is taken out by a
    // reciprocal multiply and shift, exact for every dividend below 2^29
    localparam int unsigned SIN_PRE [NUM_TERMS] = '{2, 1, 3, 1, 2, 1};
    localparam logic [29:0] SIN_RCP [NUM_TERMS] = '{30'd881018933, 30'd624722516,
                                                    30'd954437177, 30'd818089009,
                                                    30'd858993460, 30'd715827883};
    localparam int unsigned SIN_RSH [NUM_TERMS] = '{35, 35, 33, 34, 32, 31};
    localparam int unsigned COS_PRE [NUM_TERMS] = '{2, 1, 3, 1, 2, 1};
    localparam logic [29:0] COS_RCP [NUM_TERMS] = '{30'd1041204193, 30'd763549742,
                                                    30'd613566757, 30'd572662307,
                                                    30'd715827883, 30'd536870912};
    localparam int unsigned COS_RSH [NUM_TERMS] = '{35, 35, 32, 33, 31, 29};

    // reduced angle after octant folding
    typedef struct packed {
        logic [30:0] u;
        logic        upper;
        logic        quad;
    } t_fold;

    // sine and cosine of one half angle, signed q30
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sc;

    typedef struct packed {
        t_sc r;
        t_sc p;
        t_sc y;
    } t_sc3;

    // first half of a horner step: round(x2*h), then the power-of-two part
    function automatic logic [28:0] horner_pre(input logic [30:0] x2, input logic [30:0] h,
                                               input int unsigned sh);
        logic [61:0] prod;
        logic [31:0] t;
        prod = x2 * h + 62'(1 << 29);
        t    = prod[61:30] >> sh;
        return t[28:0];
    endfunction

    // second half: 2^30 - t/odd by reciprocal multiply
    function automatic logic [30:0] horner_post(input logic [28:0] tq, input logic [29:0] m,
                                                input int unsigned sh);
        logic [58:0] prod;
        logic [58:0] q;
        prod = tq * m;
        q    = prod >> sh;
        return ONE_Q30 - q[30:0];
    endfunction

    // signed q30 product, rounded half away from zero
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic        [63:0] m;
        logic        [63:0] r;
        p = a * b;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + 64'(1 << 29)) >> 30;
        return p[63] ? -32'(r) : 32'(r);
    endfunction

endpackage

// File: design/e2q_front.sv
//------------------------------------------------------------------------------
// e2q_front
// pipelined half-angle sine/cosine for three angles, one triple per cycle while not stalled
//------------------------------------------------------------------------------
module e2q_front #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [ANGLE_BITS-1:0] i_roll,
    input  logic [ANGLE_BITS-1:0] i_pitch,
    input  logic [ANGLE_BITS-1:0] i_yaw,
    input  logic                  i_stall,
    output logic                  o_valid,
    output e2q_pkg::t_sc3         o_sc
);
    import e2q_pkg::*;

    // stage 0 fold, 1 scale, 2 square, 3..14 horner (two stages a step),
    // 15 sine product, 16 quadrant
    localparam int unsigned NST = 17;
    localparam int unsigned XN  = 2 * NUM_TERMS - 1;

    logic [NST-1:0] r_vld;
    logic [30:0] r_u [3][NST-2];
    logic [30:0] r_x2 [3][XN];
    logic [28:0] r_ts [3][NUM_TERMS];
    logic [28:0] r_tc [3][NUM_TERMS];
    logic [30:0] r_hs [3][NUM_TERMS];
    logic [30:0] r_hc [3][NUM_TERMS];
    logic [30:0] r_sn [3];
    logic [30:0] r_cs [3];
    logic        r_up [3][NST-1];
    logic        r_qd [3][NST-1];
    t_sc         r_out [3];

    logic [ANGLE_BITS-1:0] ang [3];
    assign ang[0] = i_roll;
    assign ang[1] = i_pitch;
    assign ang[2] = i_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (!i_stall) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            for (int a = 0; a < 3; a++) begin
                logic [31:0] t;
                logic [63:0] xs;
                logic [61:0] sq;
                logic [61:0] sp;
                logic [31:0] sn;
                logic [31:0] cs;
                logic [31:0] ss;
                logic [31:0] cc;
                t = 32'(ang[a]) << (PHASE_BITS - ANGLE_BITS);
                r_qd[a][0] <= t[31];
                r_up[a][0] <= t[30];
                r_u[a][0]  <= t[30] ? 31'(32'h8000_0000 - {1'b0, t[30:0]}) : {1'b0, t[29:0]};
                for (int s = 1; s < NST - 1; s++) begin
                    r_up[a][s] <= r_up[a][s-1];
                    r_qd[a][s] <= r_qd[a][s-1];
                end
                xs = 64'(r_u[a][0]) * 64'(PI4_Q32) + 64'h8000_0000;
                r_u[a][1] <= 31'(xs[63:32]);
                for (int s = 2; s < NST - 2; s++) begin
                    r_u[a][s] <= r_u[a][s-1];
                end
                sq = r_u[a][1] * r_u[a][1] + 62'(1 << 29);
                r_x2[a][0] <= sq[60:30];
                for (int k = 1; k < XN; k++) begin
                    r_x2[a][k] <= r_x2[a][k-1];
                end
                r_ts[a][0] <= horner_pre(r_x2[a][0], ONE_Q30, SIN_PRE[0]);
                r_tc[a][0] <= horner_pre(r_x2[a][0], ONE_Q30, COS_PRE[0]);
                for (int j = 1; j < NUM_TERMS; j++) begin
                    r_ts[a][j] <= horner_pre(r_x2[a][2*j], r_hs[a][j-1], SIN_PRE[j]);
                    r_tc[a][j] <= horner_pre(r_x2[a][2*j], r_hc[a][j-1], COS_PRE[j]);
                end
                for (int j = 0; j < NUM_TERMS; j++) begin
                    r_hs[a][j] <= horner_post(r_ts[a][j], SIN_RCP[j], SIN_RSH[j]);
                    r_hc[a][j] <= horner_post(r_tc[a][j], COS_RCP[j], COS_RSH[j]);
                end
                sp = r_u[a][NST-3] * r_hs[a][NUM_TERMS-1] + 62'(1 << 29);
                r_sn[a] <= sp[60:30];
                r_cs[a] <= r_hc[a][NUM_TERMS-1];
                sn = 32'(r_sn[a]);
                cs = 32'(r_cs[a]);
                ss = r_up[a][NST-2] ? cs : sn;
                cc = r_up[a][NST-2] ? sn : cs;
                r_out[a].s <= r_qd[a][NST-2] ? cc : ss;
                r_out[a].c <= r_qd[a][NST-2] ? -ss : cc;
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_sc.r  = r_out[0];
    assign o_sc.p  = r_out[1];
    assign o_sc.y  = r_out[2];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |=> r_vld == $past(r_vld)) else $error("front moved while stalled");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sc.r.c <= 32'sd1073741824) && (o_sc.r.c >= -32'sd1073741824))
        else $error("roll cosine out of range");
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sc.y.s <= 32'sd1073741824) && (o_sc.y.s >= -32'sd1073741824))
        else $error("yaw sine out of range");
`endif

endmodule

// File: design/e2q_queue.sv
//------------------------------------------------------------------------------
// e2q_queue
// small fifo between the sine/cosine front and the product back
//------------------------------------------------------------------------------
module e2q_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  e2q_pkg::t_sc3 i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output e2q_pkg::t_sc3 o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import e2q_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    t_sc3                     r_mem [DEPTH];
    logic [AW-1:0]            r_wp;
    logic [AW-1:0]            r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = r_cnt != '0;
    assign o_count = r_cnt;

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == DEPTH) |-> !i_push || i_pop) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> r_wp == r_rp) else $error("pointers disagree with count");
`endif

endmodule

// File: design/e2q_back.sv
//------------------------------------------------------------------------------
// e2q_back
// triple products, sums and output rounding, with a skid-free elastic pipe
//------------------------------------------------------------------------------
module e2q_back #(
    parameter int unsigned OUT_FRAC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  e2q_pkg::t_sc3          i_sc,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_FRAC_BITS:0] o_w,
    output logic [OUT_FRAC_BITS:0] o_x,
    output logic [OUT_FRAC_BITS:0] o_y,
    output logic [OUT_FRAC_BITS:0] o_z
);
    import e2q_pkg::*;

    localparam int unsigned SH = Q - OUT_FRAC_BITS;

    // stage 1: pair products, stage 2: triples, stage 3: sums and output
    logic [2:0]         r_vld;
    logic signed [31:0] r_cc, r_sc, r_cs, r_ss, r_cy, r_sy;
    logic signed [31:0] r_t [8];
    logic [OUT_FRAC_BITS:0] r_o [4];
    logic               adv;

    assign adv     = !r_vld[2] || i_ready;
    assign o_ready = adv;

    function automatic logic [OUT_FRAC_BITS:0] to_out(input logic signed [32:0] v);
        logic        [32:0] m;
        logic        [32:0] r;
        logic signed [33:0] sr;
        m  = v[32] ? 33'(-v) : 33'(v);
        r  = (m + 33'(1 << (SH - 1))) >> SH;
        sr = v[32] ? -34'(r) : 34'(r);
        if (sr > 34'sd0 + 34'((1 << OUT_FRAC_BITS) - 1))
            return {1'b0, {OUT_FRAC_BITS{1'b1}}};
        else if (sr < -34'(1 << OUT_FRAC_BITS))
            return {1'b1, {OUT_FRAC_BITS{1'b0}}};
        else
            return sr[OUT_FRAC_BITS:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cc <= mulq(i_sc.r.c, i_sc.p.c);
            r_sc <= mulq(i_sc.r.s, i_sc.p.c);
            r_cs <= mulq(i_sc.r.c, i_sc.p.s);
            r_ss <= mulq(i_sc.r.s, i_sc.p.s);
            r_cy <= i_sc.y.c;
            r_sy <= i_sc.y.s;
            r_t[0] <= mulq(r_cc, r_cy);
            r_t[1] <= mulq(r_ss, r_sy);
            r_t[2] <= mulq(r_sc, r_cy);
            r_t[3] <= mulq(r_cs, r_sy);
            r_t[4] <= mulq(r_cs, r_cy);
            r_t[5] <= mulq(r_sc, r_sy);
            r_t[6] <= mulq(r_cc, r_sy);
            r_t[7] <= mulq(r_ss, r_cy);
            r_o[0] <= to_out(33'(r_t[0]) + 33'(r_t[1]));
            r_o[1] <= to_out(33'(r_t[2]) - 33'(r_t[3]));
            r_o[2] <= to_out(33'(r_t[4]) + 33'(r_t[5]));
            r_o[3] <= to_out(33'(r_t[6]) - 33'(r_t[7]));
        end
    end

    assign o_valid = r_vld[2];
    assign o_w = r_o[0];
    assign o_x = r_o[1];
    assign o_y = r_o[2];
    assign o_z = r_o[3];

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_w) && $stable(o_z))
        else $error("result word changed while stalled");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_vld[2] || i_ready) else $error("ready without room");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_w[OUT_FRAC_BITS] && o_w[OUT_FRAC_BITS-1:0] == '0) || 1'b1)
        else $error("unreachable");
`endif

endmodule

// File: design/euler_to_quaternion_core.sv
//------------------------------------------------------------------------------
// euler_to_quaternion_core
// binary-angle roll/pitch/yaw to signed fixed-point quaternion
//------------------------------------------------------------------------------
// Takes one angle triple per cycle when the output side keeps up. The result
// word for an accepted input passes through the 17-stage half-angle
// sine/cosine front (octant fold, scaling, squaring, six horner steps of two
// stages each, sine product, quadrant fix-up), then a 32-word queue and 3
// stages of triple products, sums and rounding. The queue credit check lets
// the sine/cosine front run on while the output is stalled; input ready drops
// only when the words in the front plus those queued already fill the queue.
module euler_to_quaternion_core #(
    parameter int unsigned ANGLE_BITS    = 16,
    parameter int unsigned OUT_FRAC_BITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ANGLE_BITS-1:0]         i_roll_angle,
    input  logic [ANGLE_BITS-1:0]         i_pitch_angle,
    input  logic [ANGLE_BITS-1:0]         i_yaw_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [OUT_FRAC_BITS:0] o_quat_w,
    output logic signed [OUT_FRAC_BITS:0] o_quat_x,
    output logic signed [OUT_FRAC_BITS:0] o_quat_y,
    output logic signed [OUT_FRAC_BITS:0] o_quat_z
);
    import e2q_pkg::*;

    localparam int unsigned QDEPTH = 32;
    localparam int unsigned FLIGHT = 17;

    logic        f_valid;
    t_sc3        f_sc;
    logic        q_valid;
    t_sc3        q_sc;
    logic        b_ready;
    logic [$clog2(QDEPTH+1)-1:0] q_cnt;
    logic [$clog2(QDEPTH+1)-1:0] r_inflight;
    logic        acc;

    // credit: words in the front plus queued must fit the queue
    assign o_ready = (32'(q_cnt) + 32'(r_inflight)) < QDEPTH;
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + (acc ? 1'b1 : 1'b0) - (f_valid ? 1'b1 : 1'b0);
        end
    end

    e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_roll  (i_roll_angle),
        .i_pitch (i_pitch_angle),
        .i_yaw   (i_yaw_angle),
        .i_stall (1'b0),
        .o_valid (f_valid),
        .o_sc    (f_sc)
    );

    e2q_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_sc),
        .i_pop   (q_valid && b_ready),
        .o_valid (q_valid),
        .o_data  (q_sc),
        .o_count (q_cnt)
    );

    e2q_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .i_sc    (q_sc),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_w     (o_quat_w),
        .o_x     (o_quat_x),
        .o_y     (o_quat_y),
        .o_z     (o_quat_z)
    );

`ifndef SYNTHESIS
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_cnt) + 32'(r_inflight) <= QDEPTH) else $error("credit overrun");
    a_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_inflight) <= FLIGHT) else $error("too many words in front");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> r_inflight != '0) else $error("front word without credit");
`endif

endmodule

// File: sim/euler_to_quaternion_core_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// euler_to_quaternion_core_test
// Sends roll/pitch/yaw angle triples with random gaps and output stalls. Each
// quaternion that comes out is checked against a fixed-point model of the
// half-angle sine/cosine and the triple-product sums. One long output stall
// makes the core fill up and drop its input ready.
//------------------------------------------------------------------------------
module euler_to_quaternion_core_test;

    localparam int AW = 16;
    localparam int OF = 15;

    typedef struct packed {
        logic signed [OF:0] w;
        logic signed [OF:0] x;
        logic signed [OF:0] y;
        logic signed [OF:0] z;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic [AW-1:0] roll_q = '0, pitch_q = '0, yaw_q = '0;
    logic core_ready, core_valid;
    logic signed [OF:0] qw, qx, qy, qz;

    t_quat quat_expected[$];
    int mismatches = 0;
    bit idle_off = 1'b0;
    bit hold_out = 1'b0;
    bit timed_out = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    euler_to_quaternion_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(core_ready),
        .i_roll_angle(roll_q), .i_pitch_angle(pitch_q), .i_yaw_angle(yaw_q),
        .o_valid(core_valid), .i_ready(out_ready),
        .o_quat_w(qw), .o_quat_x(qx), .o_quat_y(qy), .o_quat_z(qz)
    );

    // six-step horner series, unsigned q30
    function automatic longint unsigned series(longint unsigned x2, bit is_sin);
        longint unsigned h, t, k;
        h = 64'd1 << 30;
        for (int i = 0; i < 6; i++) begin
            k = is_sin ? e2q_pkg::SIN_DIV[i] : e2q_pkg::COS_DIV[i];
            t = (x2 * h + (64'd1 << 29)) >> 30;
            h = (64'd1 << 30) - t / k;
        end
        return h;
    endfunction

    function automatic void half_sin_cos(logic [AW-1:0] ang, output longint s,
                                         output longint c);
        longint unsigned t, r, u, x, x2, sn, cs;
        longint sq, cq;
        bit upper;
        t = 64'(ang) << (32 - AW);
        r = t & 64'h7FFF_FFFF;
        upper = r >= (64'd1 << 30);
        u = upper ? (64'd1 << 31) - r : r;
        x = (u * 64'd3373259426 + (64'd1 << 31)) >> 32;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        sn = (x * series(x2, 1'b1) + (64'd1 << 29)) >> 30;
        cs = series(x2, 1'b0);
        sq = upper ? longint'(cs) : longint'(sn);
        cq = upper ? longint'(sn) : longint'(cs);
        if (t[31]) begin
            s = cq;
            c = -sq;
        end else begin
            s = sq;
            c = cq;
        end
    endfunction

    function automatic longint rmul(longint a, longint b);
        longint p;
        p = a * b;
        return (p >= 0) ? (p + (64'sd1 <<< 29)) / (64'sd1 <<< 30)
                        : -((-p + (64'sd1 <<< 29)) / (64'sd1 <<< 30));
    endfunction

    function automatic logic signed [OF:0] to_q15(longint v);
        longint r;
        int sh;
        sh = 30 - OF;
        r = (v >= 0) ? (v + (64'sd1 <<< (sh - 1))) >>> sh
                     : -((-v + (64'sd1 <<< (sh - 1))) >>> sh);
        if (r > (64'sd1 <<< OF) - 1) r = (64'sd1 <<< OF) - 1;
        if (r < -(64'sd1 <<< OF)) r = -(64'sd1 <<< OF);
        return r[OF:0];
    endfunction

    function automatic t_quat quat_of(logic [AW-1:0] ro, logic [AW-1:0] pi,
                                      logic [AW-1:0] ya);
        longint sr, cr, sp, cp, sy, cy;
        t_quat q;
        half_sin_cos(ro, sr, cr);
        half_sin_cos(pi, sp, cp);
        half_sin_cos(ya, sy, cy);
        q.w = to_q15(rmul(rmul(cr, cp), cy) + rmul(rmul(sr, sp), sy));
        q.x = to_q15(rmul(rmul(sr, cp), cy) - rmul(rmul(cr, sp), sy));
        q.y = to_q15(rmul(rmul(cr, sp), cy) + rmul(rmul(sr, cp), sy));
        q.z = to_q15(rmul(rmul(cr, cp), sy) - rmul(rmul(sr, sp), cy));
        return q;
    endfunction

    // offer one word, possibly after a random gap, and wait for acceptance;
    // valid stays up on return so the next word can follow with no gap
    task automatic send_angles(logic [AW-1:0] ro, logic [AW-1:0] pi, logic [AW-1:0] ya);
        while (!idle_off && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        roll_q <= ro;
        pitch_q <= pi;
        yaw_q <= ya;
        quat_expected.push_back(quat_of(ro, pi, ya));
        do @(posedge i_clk); while (!core_ready);
    endtask

    // output ready: random stalls unless held or quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= !hold_out && (idle_off || $urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        t_quat e;
        if (i_rst_n && core_valid && out_ready) begin
            if (quat_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word w=%0d x=%0d y=%0d z=%0d", qw, qx, qy, qz);
            end else begin
                e = quat_expected.pop_front();
                if (e.w !== qw || e.x !== qx || e.y !== qy || e.z !== qz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                                 e.w, e.x, e.y, e.z, qw, qx, qy, qz);
                end
            end
        end
    end

    task automatic test_directed();
        logic [AW-1:0] corners[10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                       16'h2000, 16'h6000, 16'h3FFF, 16'h7FFF, 16'h8001};
        foreach (corners[i]) send_angles(corners[i], 16'h0000, 16'h0000);
        foreach (corners[i]) send_angles(16'h0000, corners[i], corners[9 - i]);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_quiet(int n);
        idle_off = 1'b1;
        test_random(n);
        idle_off = 1'b0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_out = 1'b0;
            end
            begin
                test_random(60);
                in_valid <= 1'b0;
            end
        join
        @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(800);
        test_quiet(300);
        test_backpressure();
        test_random(660);
        in_valid <= 1'b0;
        while (quat_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && !timed_out) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        timed_out = 1'b1;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
